@@ design/hpdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdp_pkg
// Shared types and constants for the Hamiltonian path subset DP block.
// ----------------------------------------------------------------------------
package hpdp_pkg;

  // default largest graph size
  localparam int MAX_NODES_DEF = 16;

  // command codes carried by the opcode field
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

endpackage

@@ design/hpdp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (returns old data on a same-address write).
// ----------------------------------------------------------------------------
module hpdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/hamiltonian_path_bitmask_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamiltonian_path_bitmask_dp
// Holds a directed graph and answers Hamiltonian path queries with the
// subset dynamic programme, kept in one reach-table RAM.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_ready  | opcode, edge_from, edge_to, path_start,
//          |                     | path_end, node_count
//  output  | out_valid, out_ready| path_exists
//
// In a query over n nodes, every subset is built from n reads, one per node,
// through the single read port of the reach RAM.
// A query with a bad node count, start or end goes straight to done with 0.
// Reset (rst, synchronous) empties the graph; the reach RAM needs no clear,
// since each query writes every entry that it uses before it reads it.
// The block runs one query at a time; a result waiting on out_ready does
// not stop clear or edge transactions, only the end of the next query.
// ----------------------------------------------------------------------------
module hamiltonian_path_bitmask_dp #(
  parameter int MAX_NODES = hpdp_pkg::MAX_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [3:0] edge_from,
  input  logic [3:0] edge_to,
  input  logic [3:0] path_start,
  input  logic [3:0] path_end,
  input  logic [4:0] node_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       path_exists
);

  import hpdp_pkg::*;

  localparam int MASK_W  = MAX_NODES;
  localparam int MASK_W1 = MASK_W + 1;
  localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [4:0] MAX_N5 = 5'(MAX_NODES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state;

  // predecessor sets: bit i of pred[k] means an edge i->k
  logic [MASK_W-1:0] pred [MAX_NODES];

  // query setup
  logic [MASK_W-1:0] full_r;
  logic [MASK_W-1:0] start_bit;
  logic [NODE_W-1:0] end_r;
  logic [NODE_W-1:0] n_m1;
  logic              res;

  // issue stage
  logic [MASK_W-1:0] m;
  logic [NODE_W-1:0] k;
  logic              issue_done;
  logic              rd_en;
  logic [MASK_W-1:0] rd_addr;
  logic [MASK_W-1:0] rd_data;

  // data stage
  logic              d_vld;
  logic [MASK_W-1:0] d_m;
  logic [NODE_W-1:0] d_k;
  logic              d_last;
  logic              d_fwd;
  logic [MASK_W-1:0] fwd_data;
  logic [MASK_W-1:0] acc;
  logic [MASK_W-1:0] acc_next;
  logic [MASK_W-1:0] rd_val;
  logic              hit;
  logic              wr_en;
  logic [MASK_W-1:0] wr_data;

  logic              in_xfer;
  opcode_t           op;
  logic              bad_query;
  logic [MASK_W:0]   pow_n;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign op       = opcode_t'(opcode);

  // query range checks and full mask
  assign bad_query = (node_count == 5'd0) || (node_count > MAX_N5) ||
                     ({1'b0, path_start} >= node_count) ||
                     ({1'b0, path_end} >= node_count);
  assign pow_n = MASK_W1'(1) << node_count;

  // graph storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        pred[i] <= '0;
      end
    end else if (in_xfer) begin
      unique case (op)
        OP_CLEAR: begin
          for (int i = 0; i < MAX_NODES; i++) begin
            pred[i] <= '0;
          end
        end
        OP_EDGE: begin
          if (({1'b0, edge_from} < MAX_N5) && ({1'b0, edge_to} < MAX_N5)) begin
            pred[NODE_W'(edge_to)][NODE_W'(edge_from)] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // read address: subset m with bit k flipped (without node k when k is in m)
  assign rd_en   = (state == S_RUN) && !issue_done;
  assign rd_addr = m ^ (MASK_W'(1) << k);

  // combine returned entry with predecessors of node d_k
  always_comb begin
    rd_val   = d_fwd ? fwd_data : rd_data;
    hit      = d_m[d_k] && (|(rd_val & pred[d_k]));
    acc_next = acc | (MASK_W'(hit) << d_k);
    wr_en    = d_vld && d_last;
    wr_data  = acc_next | ((d_m == start_bit) ? start_bit : '0);
  end

  hpdp_ram #(
    .WIDTH(MASK_W),
    .DEPTH(2 ** MAX_NODES)
  ) u_reach (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(d_m),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // data stage and forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= rd_en;
    end
    d_m      <= m;
    d_k      <= k;
    d_last   <= (k == n_m1);
    d_fwd    <= wr_en && (rd_addr == d_m);
    fwd_data <= wr_data;
  end

  // control, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      // the done state loads the next result itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && op == OP_QUERY) begin
            if (bad_query) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              full_r     <= MASK_W'(pow_n - 1'b1);
              start_bit  <= MASK_W'(1) << path_start;
              end_r      <= NODE_W'(path_end);
              n_m1       <= NODE_W'(node_count - 5'd1);
              m          <= '0;
              k          <= '0;
              acc        <= '0;
              issue_done <= 1'b0;
              state      <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (rd_en) begin
            if (k == n_m1) begin
              k <= '0;
              if (m == full_r) begin
                issue_done <= 1'b1;
              end else begin
                m <= m + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
          if (d_vld) begin
            acc <= d_last ? '0 : acc_next;
          end
          if (wr_en && d_m == full_r) begin
            res   <= wr_data[end_r];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            path_exists <= res;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // RAM writes happen only while a query runs
  a_wr_in_run: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_RUN)
    else $error("reach table written outside a query");

  // returned data always follows an issued read
  a_data_follows_read: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> $past(rd_en))
    else $error("data stage valid without a read");

  // accumulated end nodes stay inside the current subset
  a_acc_in_mask: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> (acc & ~d_m) == '0)
    else $error("end node outside its subset");

  // the last subset written ends the query
  a_full_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && wr_en && d_m == full_r) |=> state == S_DONE)
    else $error("query did not finish after the full subset");

endmodule
